@@ hdl/gzdt_pkg.sv @@
`default_nettype none

package gzdt_pkg;

  // Grid limits and the widths that follow from them.
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELLS    = 2 ** ADDR_W;
  localparam int PTR_W    = ADDR_W + 1;

  // Fixed field widths.
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 6;
  localparam int SIZE_W    = 7;
  localparam int DIST_W    = 7;
  localparam int CELL_W    = DIST_W + 1;
  localparam int CFG_IDX_W = 2;

  // Common width for comparing coordinates against the grid size.
  localparam int RC_MAX = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int CMP_W  = ((RC_MAX > SIZE_W) ? RC_MAX : SIZE_W) + 1;

  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Result kinds.
  localparam logic RK_DONE = 1'b0;
  localparam logic RK_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

  // Neighbour slots, in search order.
  localparam int NB_UP    = 0;
  localparam int NB_DOWN  = 1;
  localparam int NB_LEFT  = 2;
  localparam int NB_RIGHT = 3;
  localparam int NB_NUM   = 4;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } nbr_t;

  // A size of zero acts as one; a size above the maximum acts as the maximum.
  function automatic logic [CMP_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                  input logic [CMP_W-1:0]  mx);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w == '0) begin
      clamp_size = CMP_W'(1);
    end else if (w > mx) begin
      clamp_size = mx;
    end else begin
      clamp_size = w;
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/gzdt_ram.sv @@
`default_nettype none

module gzdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/gzdt_nbr.sv @@
`default_nettype none

// Works out the four neighbours of the current cell and whether each lies
// inside the grid in use.
module gzdt_nbr (
  input  wire logic [gzdt_pkg::ADDR_W-1:0] cur_addr,
  input  wire logic [gzdt_pkg::CMP_W-1:0]  rows_eff,
  input  wire logic [gzdt_pkg::CMP_W-1:0]  cols_eff,
  output gzdt_pkg::nbr_t [gzdt_pkg::NB_NUM-1:0] nbs
);

  logic [gzdt_pkg::ROW_W-1:0] cr;
  logic [gzdt_pkg::COL_W-1:0] cc;

  assign cr = cur_addr[gzdt_pkg::ADDR_W-1:gzdt_pkg::COL_W];
  assign cc = cur_addr[gzdt_pkg::COL_W-1:0];

  always_comb begin
    nbs[gzdt_pkg::NB_UP].valid    = (cr != '0);
    nbs[gzdt_pkg::NB_UP].addr     = {cr - gzdt_pkg::ROW_W'(1), cc};
    nbs[gzdt_pkg::NB_DOWN].valid  = (gzdt_pkg::CMP_W'(cr) + gzdt_pkg::CMP_W'(1)) < rows_eff;
    nbs[gzdt_pkg::NB_DOWN].addr   = {cr + gzdt_pkg::ROW_W'(1), cc};
    nbs[gzdt_pkg::NB_LEFT].valid  = (cc != '0);
    nbs[gzdt_pkg::NB_LEFT].addr   = {cr, cc - gzdt_pkg::COL_W'(1)};
    nbs[gzdt_pkg::NB_RIGHT].valid = (gzdt_pkg::CMP_W'(cc) + gzdt_pkg::CMP_W'(1)) < cols_eff;
    nbs[gzdt_pkg::NB_RIGHT].addr  = {cr, cc + gzdt_pkg::COL_W'(1)};
  end

endmodule

`default_nettype wire

@@ hdl/grid_zero_distance_transform_core.sv @@
`default_nettype none

// Channel   Direction  Handshake                Payload
// input     in         start & !busy            in_cmd, in_row_index, in_col_index, in_cell_bit
// result    out        out_valid (one cycle)    out_result_kind, out_distance, out_bad_address
// config    in         cfg_valid & cfg_ready    cfg_index, cfg_data
//
// A cell write gives a result only for an address outside the grid; a cell read passes through
// the read-wait state. Every result is registered. A run reads each in-grid cell in raster order
// to seed the queue, then reads each queued cell and its neighbours through the single read port
// of the cell memory. Reset is synchronous and active low; it returns the grid size to 64 by 64
// and needs no clearing pass. The receiver takes every result as it appears.
module grid_zero_distance_transform_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [gzdt_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [gzdt_pkg::IDX_W-1:0]       in_row_index,
  input  wire logic [gzdt_pkg::IDX_W-1:0]       in_col_index,
  input  wire logic                             in_cell_bit,
  output logic                                  out_valid,
  output logic                                  out_result_kind,
  output logic      [gzdt_pkg::DIST_W-1:0]      out_distance,
  output logic                                  out_bad_address,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [gzdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gzdt_pkg::SIZE_W-1:0]      cfg_data
);

  // Sequencer states. The seed pass reads each in-grid cell and writes it back with its
  // visited flag; the search then takes cells from the queue and handles their neighbours.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RDWAIT   = 3'd1;
  localparam logic [2:0] ST_SEED     = 3'd2;
  localparam logic [2:0] ST_SEED_END = 3'd3;
  localparam logic [2:0] ST_QCHK     = 3'd4;
  localparam logic [2:0] ST_QDATA    = 3'd5;
  localparam logic [2:0] ST_CUR      = 3'd6;
  localparam logic [2:0] ST_NB       = 3'd7;

  localparam int AW = gzdt_pkg::ADDR_W;

  logic [2:0]                      state_r, state_nxt;
  logic [gzdt_pkg::SIZE_W-1:0]     grid_rows_r, grid_cols_r;
  logic [gzdt_pkg::ROW_W-1:0]      sr_r, sr_nxt;
  logic [gzdt_pkg::COL_W-1:0]      sc_r, sc_nxt;
  logic                            pend_r, pend_nxt;
  logic [AW-1:0]                   pend_addr_r, pend_addr_nxt;
  logic [gzdt_pkg::PTR_W-1:0]      head_r, head_nxt;
  logic [gzdt_pkg::PTR_W-1:0]      tail_r, tail_nxt;
  logic [AW-1:0]                   cur_addr_r, cur_addr_nxt;
  logic [gzdt_pkg::DIST_W-1:0]     next_r, next_nxt;
  logic [1:0]                      k_r, k_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_kind_r, out_kind_nxt;
  logic [gzdt_pkg::DIST_W-1:0]     out_dist_r, out_dist_nxt;
  logic                            out_bad_r, out_bad_nxt;

  // Cell memory: bit DIST_W is the visited flag, the rest the value or distance.
  logic                            cm_we;
  logic [AW-1:0]                   cm_waddr, cm_raddr;
  logic [gzdt_pkg::CELL_W-1:0]     cm_wdata, cm_rdata;

  // Frontier queue memory.
  logic                            qm_we;
  logic [AW-1:0]                   qm_waddr, qm_raddr;
  logic [AW-1:0]                   qm_wdata, qm_rdata;

  logic [gzdt_pkg::CMP_W-1:0]      rows_eff, cols_eff;
  logic                            bad_addr;
  logic [AW-1:0]                   in_addr;
  logic                            seed_last;
  logic [gzdt_pkg::DIST_W-1:0]     cur_val;
  gzdt_pkg::nbr_t [gzdt_pkg::NB_NUM-1:0] nbs;
  gzdt_pkg::nbr_t                  nb_now, nb_ahead;

  assign rows_eff = gzdt_pkg::clamp_size(grid_rows_r, gzdt_pkg::CMP_W'(gzdt_pkg::MAX_ROWS));
  assign cols_eff = gzdt_pkg::clamp_size(grid_cols_r, gzdt_pkg::CMP_W'(gzdt_pkg::MAX_COLS));

  assign bad_addr = (gzdt_pkg::CMP_W'(in_row_index) >= rows_eff) ||
                    (gzdt_pkg::CMP_W'(in_col_index) >= cols_eff);
  assign in_addr  = {gzdt_pkg::ROW_W'(in_row_index), gzdt_pkg::COL_W'(in_col_index)};

  assign seed_last = ((gzdt_pkg::CMP_W'(sr_r) + gzdt_pkg::CMP_W'(1)) == rows_eff) &&
                     ((gzdt_pkg::CMP_W'(sc_r) + gzdt_pkg::CMP_W'(1)) == cols_eff);

  assign cur_val  = cm_rdata[gzdt_pkg::DIST_W-1:0];
  assign nb_now   = nbs[k_r];
  assign nb_ahead = nbs[k_r + 2'd1];

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_distance    = out_dist_r;
  assign out_bad_address = out_bad_r;

  gzdt_nbr u_nbr (
    .cur_addr (cur_addr_r),
    .rows_eff (rows_eff),
    .cols_eff (cols_eff),
    .nbs      (nbs)
  );

  gzdt_ram #(
    .WIDTH (gzdt_pkg::CELL_W),
    .DEPTH (gzdt_pkg::CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (cm_wdata),
    .raddr (cm_raddr),
    .rdata (cm_rdata)
  );

  gzdt_ram #(
    .WIDTH (AW),
    .DEPTH (gzdt_pkg::CELLS)
  ) u_queue_ram (
    .clk   (clk),
    .we    (qm_we),
    .waddr (qm_waddr),
    .wdata (qm_wdata),
    .raddr (qm_raddr),
    .rdata (qm_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    sr_nxt        = sr_r;
    sc_nxt        = sc_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_addr_nxt  = cur_addr_r;
    next_nxt      = next_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_dist_nxt  = out_dist_r;
    out_bad_nxt   = out_bad_r;
    cm_we         = 1'b0;
    cm_waddr      = in_addr;
    cm_wdata      = {{gzdt_pkg::DIST_W{1'b0}}, in_cell_bit};
    cm_raddr      = in_addr;
    qm_we         = 1'b0;
    qm_waddr      = tail_r[AW-1:0];
    qm_wdata      = pend_addr_r;
    qm_raddr      = head_r[AW-1:0];

    // The seed pass writes back the cell read in the previous cycle: sources are marked
    // visited and pushed on the queue, every other in-grid cell is marked unvisited.
    if (((state_r == ST_SEED) || (state_r == ST_SEED_END)) && pend_r) begin
      cm_we    = 1'b1;
      cm_waddr = pend_addr_r;
      cm_wdata = {(cur_val == '0), cur_val};
      if (cur_val == '0) begin
        qm_we    = 1'b1;
        tail_nxt = tail_r + gzdt_pkg::PTR_W'(1);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_cmd)
            gzdt_pkg::CMD_WRITE: begin
              if (bad_addr) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = gzdt_pkg::RK_READ;
                out_dist_nxt  = '0;
                out_bad_nxt   = 1'b1;
              end else begin
                cm_we = 1'b1;
              end
            end
            gzdt_pkg::CMD_RUN: begin
              sr_nxt    = '0;
              sc_nxt    = '0;
              head_nxt  = '0;
              tail_nxt  = '0;
              state_nxt = ST_SEED;
            end
            gzdt_pkg::CMD_READ: begin
              if (bad_addr) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = gzdt_pkg::RK_READ;
                out_dist_nxt  = '0;
                out_bad_nxt   = 1'b1;
              end else begin
                state_nxt = ST_RDWAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_RDWAIT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = gzdt_pkg::RK_READ;
        out_dist_nxt  = cur_val;
        out_bad_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end

      ST_SEED: begin
        // Read the next cell in raster order while the previous one is written back.
        cm_raddr      = {sr_r, sc_r};
        pend_nxt      = 1'b1;
        pend_addr_nxt = {sr_r, sc_r};
        if (seed_last) begin
          state_nxt = ST_SEED_END;
        end else if ((gzdt_pkg::CMP_W'(sc_r) + gzdt_pkg::CMP_W'(1)) == cols_eff) begin
          sc_nxt = '0;
          sr_nxt = sr_r + gzdt_pkg::ROW_W'(1);
        end else begin
          sc_nxt = sc_r + gzdt_pkg::COL_W'(1);
        end
      end

      ST_SEED_END: begin
        state_nxt = ST_QCHK;
      end

      ST_QCHK: begin
        if (head_r == tail_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = gzdt_pkg::RK_DONE;
          out_dist_nxt  = '0;
          out_bad_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          head_nxt  = head_r + gzdt_pkg::PTR_W'(1);
          state_nxt = ST_QDATA;
        end
      end

      ST_QDATA: begin
        cur_addr_nxt = qm_rdata;
        cm_raddr     = qm_rdata;
        state_nxt    = ST_CUR;
      end

      ST_CUR: begin
        // The current cell's distance plus one, held at the top of the range.
        next_nxt  = (cur_val == gzdt_pkg::DIST_MAX) ? gzdt_pkg::DIST_MAX
                                                    : cur_val + gzdt_pkg::DIST_W'(1);
        cm_raddr  = nbs[gzdt_pkg::NB_UP].addr;
        k_nxt     = 2'd0;
        state_nxt = ST_NB;
      end

      ST_NB: begin
        // Handle the neighbour read last cycle and read the one after it.
        if (nb_now.valid && !cm_rdata[gzdt_pkg::DIST_W]) begin
          cm_we    = 1'b1;
          cm_waddr = nb_now.addr;
          cm_wdata = {1'b1, next_r};
          qm_we    = 1'b1;
          qm_wdata = nb_now.addr;
          tail_nxt = tail_r + gzdt_pkg::PTR_W'(1);
        end
        cm_raddr = nb_ahead.addr;
        if (k_r == 2'(gzdt_pkg::NB_RIGHT)) begin
          state_nxt = ST_QCHK;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      grid_rows_r <= gzdt_pkg::SIZE_RESET;
      grid_cols_r <= gzdt_pkg::SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gzdt_pkg::REG_GRID_ROWS) begin
          grid_rows_r <= cfg_data;
        end else if (cfg_index == gzdt_pkg::REG_GRID_COLS) begin
          grid_cols_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sr_r        <= sr_nxt;
    sc_r        <= sc_nxt;
    pend_addr_r <= pend_addr_nxt;
    cur_addr_r  <= cur_addr_nxt;
    next_r      <= next_nxt;
    k_r         <= k_nxt;
    out_kind_r  <= out_kind_nxt;
    out_dist_r  <= out_dist_nxt;
    out_bad_r   <= out_bad_nxt;
  end

endmodule

`default_nettype wire

@@ bench/grid_zero_distance_transform_core_tb.sv @@
`default_nettype none

module grid_zero_distance_transform_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gzdt_pkg::*;

  // Command code and register indexes that the package leaves unnamed.
  localparam logic [CMD_W-1:0]     CMD_NONE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int RANDOM_ITEMS  = 30;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 400000;

  // One command as it is presented on the input ports.
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             cell_bit;
  } grid_cmd_t;

  // One reply as the block should deliver it.
  typedef struct {
    logic              kind;
    logic [DIST_W-1:0] dval;
    logic              bad;
  } cell_reply_t;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 start        = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     in_cmd       = '0;
  logic [IDX_W-1:0]     in_row_index = '0;
  logic [IDX_W-1:0]     in_col_index = '0;
  logic                 in_cell_bit  = 1'b0;
  logic                 out_valid;
  logic                 out_result_kind;
  logic [DIST_W-1:0]    out_distance;
  logic                 out_bad_address;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [SIZE_W-1:0]    cfg_data     = '0;

  grid_zero_distance_transform_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_cell_bit     (in_cell_bit),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_distance    (out_distance),
    .out_bad_address (out_bad_address),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Commands waiting to be presented, and replies still owed by the block.
  grid_cmd_t   cmd_backlog[$];
  cell_reply_t pending_replies[$];

  int cmds_queued   = 0;
  int cmds_accepted = 0;
  int fault_count   = 0;
  int mixed_count   = 0;
  int cycle_count   = 0;
  int gap_left      = 0;
  bit idling_on     = 1'b1;

  // The predictor's own copy of the grid and of the two size registers. The
  // grid region that the stimulus generator believes is in use is kept apart
  // from these, so that the generator never depends on prediction timing.
  logic [DIST_W-1:0] grid_val [CELLS];
  bit                reached  [CELLS];
  logic [SIZE_W-1:0] rows_setting = SIZE_W'(64);
  logic [SIZE_W-1:0] cols_setting = SIZE_W'(64);
  int                gen_rows     = MAX_ROWS;
  int                gen_cols     = MAX_COLS;

  // A size of zero behaves as one and anything above the maximum as the maximum.
  function automatic int span(logic [SIZE_W-1:0] raw, int limit);
    if (raw == '0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  function automatic void owe_reply(logic kind, logic [DIST_W-1:0] dval, logic bad);
    cell_reply_t rep;
    rep.kind = kind;
    rep.dval = dval;
    rep.bad  = bad;
    pending_replies.push_back(rep);
  endfunction

  // Multi-source breadth-first search: every zero cell of the region is a
  // seed, taken in raster order, and each newly reached neighbour (up, down,
  // left, right) gets its parent's distance plus one.
  function automatic void relax_grid(int rows, int cols);
    int                fifo[$];
    int                a, r, c, nr, nc, na, k;
    logic [DIST_W-1:0] nxt;
    for (int i = 0; i < CELLS; i++) reached[i] = 1'b0;
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        a = r * MAX_COLS + c;
        if (grid_val[a] == '0) begin
          fifo.push_back(a);
          reached[a] = 1'b1;
        end
      end
    end
    while (fifo.size() > 0) begin
      a   = fifo.pop_front();
      r   = a / MAX_COLS;
      c   = a % MAX_COLS;
      nxt = (grid_val[a] == DIST_MAX) ? DIST_MAX : grid_val[a] + 1'b1;
      for (k = 0; k < NB_NUM; k++) begin
        nr = r;
        nc = c;
        case (k)
          NB_UP:   nr = r - 1;
          NB_DOWN: nr = r + 1;
          NB_LEFT: nc = c - 1;
          default: nc = c + 1;
        endcase
        if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
          na = nr * MAX_COLS + nc;
          if (!reached[na]) begin
            grid_val[na] = nxt;
            reached[na]  = 1'b1;
            fifo.push_back(na);
          end
        end
      end
    end
  endfunction

  // Advances the predicted grid by one accepted command and records the reply
  // it owes, if any.
  function automatic void apply_command(grid_cmd_t item);
    int rows, cols, a;
    bit off;
    rows = span(rows_setting, MAX_ROWS);
    cols = span(cols_setting, MAX_COLS);
    off  = (int'(item.row) >= rows) || (int'(item.col) >= cols);
    a    = int'(item.row) * MAX_COLS + int'(item.col);
    case (item.cmd)
      CMD_WRITE: begin
        if (off) owe_reply(RK_READ, '0, 1'b1);
        else grid_val[a] = DIST_W'(item.cell_bit);
      end
      CMD_RUN: begin
        relax_grid(rows, cols);
        owe_reply(RK_DONE, '0, 1'b0);
      end
      CMD_READ: begin
        if (off) owe_reply(RK_READ, '0, 1'b1);
        else owe_reply(RK_READ, grid_val[a], 1'b0);
      end
      default: ;
    endcase
  endfunction

  // Command driver. A command is transferred at an edge where start is high
  // and busy is low; the prediction is made at that same edge, before the
  // transfer is counted, so that anyone who sees the count also sees the
  // reply it owes. Short random gaps are inserted between commands while
  // idling is enabled.
  always @(posedge clk) begin : cmd_driver
    grid_cmd_t held, nxt;
    if (rst_n) begin
      if (start && !busy) begin
        held.cmd      = in_cmd;
        held.row      = in_row_index;
        held.col      = in_col_index;
        held.cell_bit = in_cell_bit;
        apply_command(held);
        cmds_accepted++;
        if (idling_on && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 3);
      end
      // Either the port is empty or its command has just been transferred,
      // so a new one may be presented.
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          nxt           = cmd_backlog.pop_front();
          start        <= 1'b1;
          in_cmd       <= nxt.cmd;
          in_row_index <= nxt.row;
          in_col_index <= nxt.col;
          in_cell_bit  <= nxt.cell_bit;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Reply monitor. The block cannot be held off, so every strobe is a
  // transfer and is checked against the oldest reply still owed.
  always @(posedge clk) begin : reply_check
    cell_reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $error("result with nothing expected: kind %0d distance %0d bad_address %0d",
               out_result_kind, out_distance, out_bad_address);
        fault_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, out_result_kind);
          fault_count++;
        end
        if (out_distance !== want.dval) begin
          $error("distance: expected %0d, got %0d", want.dval, out_distance);
          fault_count++;
        end
        if (out_bad_address !== want.bad) begin
          $error("bad_address: expected %0d, got %0d", want.bad, out_bad_address);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void queue_cmd(logic [CMD_W-1:0] cmd, int row, int col, logic cell_bit);
    grid_cmd_t item;
    item.cmd      = cmd;
    item.row      = IDX_W'(row);
    item.col      = IDX_W'(col);
    item.cell_bit = cell_bit;
    cmd_backlog.push_back(item);
    cmds_queued++;
  endfunction

  // Returns once every queued command has been transferred, every owed reply
  // has arrived and the block is no longer busy. A good write owes nothing,
  // so a few more cycles are allowed for it to land before the caller moves on.
  task automatic wait_quiet();
    while (cmds_accepted != cmds_queued || pending_replies.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write over the configuration channel. Valid is dropped for a
  // cycle afterwards so that back-to-back writes never collide on one edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRID_ROWS: rows_setting = val;
      REG_GRID_COLS: cols_setting = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_size(logic [SIZE_W-1:0] raw_rows, logic [SIZE_W-1:0] raw_cols);
    wait_quiet();
    write_reg(REG_GRID_ROWS, raw_rows);
    write_reg(REG_GRID_COLS, raw_cols);
    gen_rows = span(raw_rows, MAX_ROWS);
    gen_cols = span(raw_cols, MAX_COLS);
  endtask

  // Writes every cell of the region in use; zero_pct is the chance, in
  // percent, that a cell becomes a source.
  function automatic void fill_region(int zero_pct);
    for (int r = 0; r < gen_rows; r++)
      for (int c = 0; c < gen_cols; c++)
        queue_cmd(CMD_WRITE, r, c, $urandom_range(0, 99) >= zero_pct);
  endfunction

  // One random command. The whole region has been written before this is
  // called, so any in-range read is safe; addresses may also fall anywhere,
  // or deliberately outside the region.
  function automatic void mixed_item();
    int pick, op, r, c;
    pick = $urandom_range(0, 99);
    op   = $urandom_range(0, 99);
    r    = $urandom_range(0, gen_rows - 1);
    c    = $urandom_range(0, gen_cols - 1);
    if (pick < 10) begin
      r = $urandom_range(0, 63);
      c = $urandom_range(0, 63);
    end else if (pick < 25 && (gen_rows < MAX_ROWS || gen_cols < MAX_COLS)) begin
      if (gen_rows < MAX_ROWS && (gen_cols == MAX_COLS || $urandom_range(0, 1) == 1))
        r = $urandom_range(gen_rows, 63);
      else
        c = $urandom_range(gen_cols, 63);
    end
    if (op < 40) queue_cmd(CMD_WRITE, r, c, $urandom_range(0, 1));
    else if (op < 80) queue_cmd(CMD_READ, r, c, $urandom_range(0, 1));
    else if (op < 93) queue_cmd(CMD_RUN, r, c, $urandom_range(0, 1));
    else begin
      // Command 3 is simply dropped by the block and does not count.
      queue_cmd(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
      return;
    end
    mixed_count++;
  endfunction

  initial begin : stimulus
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // At the reset size of 64 by 64 only isolated cells are written, so no
    // run takes place here; the far corner exercises the top address bits.
    queue_cmd(CMD_WRITE, 63, 63, 1'b1);
    queue_cmd(CMD_WRITE, 0, 0, 1'b0);
    queue_cmd(CMD_WRITE, 63, 0, 1'b0);
    queue_cmd(CMD_READ, 63, 63, 1'b0);
    queue_cmd(CMD_READ, 0, 0, 1'b1);
    queue_cmd(CMD_READ, 63, 0, 1'b1);
    queue_cmd(CMD_NONE, 63, 63, 1'b1);

    // A 3 by 3 grid: first with no source at all, which a run must leave
    // untouched, then with a source in the middle.
    set_size(3, 3);
    fill_region(0);
    queue_cmd(CMD_RUN, 0, 0, 1'b0);
    queue_cmd(CMD_READ, 0, 0, 1'b0);
    queue_cmd(CMD_WRITE, 1, 1, 1'b0);
    queue_cmd(CMD_RUN, 0, 0, 1'b0);
    queue_cmd(CMD_READ, 0, 0, 1'b0);
    queue_cmd(CMD_READ, 1, 1, 1'b0);
    queue_cmd(CMD_READ, 2, 2, 1'b0);
    queue_cmd(CMD_READ, 0, 1, 1'b0);
    // Writes and reads outside the grid are refused with a flag.
    queue_cmd(CMD_WRITE, 3, 0, 1'b0);
    queue_cmd(CMD_READ, 0, 63, 1'b0);
    queue_cmd(CMD_READ, 63, 63, 1'b0);
    // A second source in the corner; the old distances are overwritten.
    queue_cmd(CMD_WRITE, 0, 0, 1'b0);
    queue_cmd(CMD_RUN, 0, 0, 1'b0);
    queue_cmd(CMD_READ, 2, 2, 1'b0);
    queue_cmd(CMD_READ, 0, 2, 1'b0);

    // Writes to indexes beyond the two size registers must change nothing.
    wait_quiet();
    write_reg(REG_SPARE_LO, 7'h55);
    write_reg(REG_SPARE_HI, 7'h2A);
    queue_cmd(CMD_READ, 2, 2, 1'b0);
    queue_cmd(CMD_READ, 2, 3, 1'b0);

    // Sizes beyond the maximum act as the maximum, so the far corners stay in
    // range and keep the values written at the reset size.
    set_size(127, 127);
    queue_cmd(CMD_READ, 63, 63, 1'b0);
    queue_cmd(CMD_WRITE, 63, 63, 1'b0);
    queue_cmd(CMD_READ, 63, 63, 1'b0);
    queue_cmd(CMD_READ, 63, 0, 1'b0);

    // Random phases. The first two take one size register to zero; the rest
    // use grids of up to 4 by 4 so that runs stay short. Each phase loads the
    // whole region, runs once and then mixes writes, reads and runs. Idling
    // stops for the final stretch.
    phase = 0;
    while (phase < 2 || mixed_count < RANDOM_ITEMS) begin
      case (phase)
        0:       set_size(0, 4);
        1:       set_size(4, 0);
        default: set_size($urandom_range(0, 4), $urandom_range(0, 4));
      endcase
      idling_on = (mixed_count < RANDOM_ITEMS * 3 / 4);
      fill_region(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 40));
      queue_cmd(CMD_RUN, 0, 0, 1'b0);
      repeat ($urandom_range(6, 10)) mixed_item();
      phase++;
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ grid_zero_distance_transform_core.f @@
hdl/gzdt_pkg.sv
hdl/gzdt_ram.sv
hdl/gzdt_nbr.sv
hdl/grid_zero_distance_transform_core.sv
bench/grid_zero_distance_transform_core_tb.sv
